// ===== hdl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, codes and saturating arithmetic for the perceptron block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  localparam int  CoordW     = 32;
  localparam int  AccW       = 64;
  localparam int  DimW       = 10;
  localparam logic KIND_TRAIN = 1'b0;

  typedef enum logic [3:0] {
    ST_CLR = 4'b0001,
    ST_RUN = 4'b0010,
    ST_FIN = 4'b0100,
    ST_UPD = 4'b1000
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctl_t;

  typedef struct packed {
    logic wr_en;
    logic clear;
    logic add;
  } wmem_ctl_t;

  function automatic logic signed [AccW-1:0] sat_add64(
    input logic signed [AccW-1:0] a,
    input logic signed [AccW-1:0] b
  );
    logic signed [AccW:0] s;
    logic signed [AccW-1:0] r;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      r = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = s[AccW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] sat_upd32(
    input logic signed [CoordW-1:0] w,
    input logic signed [CoordW-1:0] d,
    input logic                     add
  );
    logic signed [CoordW:0] s;
    logic signed [CoordW-1:0] r;
    if (add) begin
      s = {w[CoordW-1], w} + {d[CoordW-1], d};
    end else begin
      s = {w[CoordW-1], w} - {d[CoordW-1], d};
    end
    if (s[CoordW] != s[CoordW-1]) begin
      r = s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      r = s[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ptc_mac.sv =====
// ----------------------------------------------------------------------------
// ptc_mac
// Registered 32x32 product followed by a saturating 64-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_mac
  import ptc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [CoordW-1:0] x,
  input  wire logic signed [CoordW-1:0] w,
  output logic                          acc_pos
);

  logic signed [AccW-1:0] prod_r;
  logic signed [AccW-1:0] acc_r;
  logic signed [AccW-1:0] acc_nxt;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= AccW'(x) * AccW'(w);
    end
  end

  always_comb begin
    priority if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_nxt = sat_add64(acc_r, prod_r);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_pos = !acc_r[AccW-1] && (|acc_r);

endmodule

`default_nettype wire

// ===== hdl/ptc_wmem.sv =====
// ----------------------------------------------------------------------------
// ptc_wmem
// Weight memory: one registered read port, one write port that writes zero
// during the clearing pass or the saturated update of the word just read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_wmem
  import ptc_pkg::*;
#(
  parameter int Depth = 512,
  parameter int AddrW = 9
) (
  input  wire logic                     clk,
  input  wire wmem_ctl_t                ctl,
  input  wire logic [AddrW-1:0]         rd_addr,
  input  wire logic [AddrW-1:0]         wr_addr,
  input  wire logic signed [CoordW-1:0] vec_data,
  output logic signed [CoordW-1:0]      rd_data
);

  logic signed [CoordW-1:0] mem [Depth];
  logic signed [CoordW-1:0] rd_data_r;
  logic signed [CoordW-1:0] wr_data;

  // rd_data belongs to wr_addr during an update pass
  assign wr_data = ctl.clear ? '0 : sat_upd32(rd_data_r, vec_data, ctl.add);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/perceptron_train_classify.sv =====
// ----------------------------------------------------------------------------
// perceptron_train_classify
// Binary perceptron: streams coordinates, classifies, trains on mismatch.
// ----------------------------------------------------------------------------
// Coordinates are taken one per clock while a vector is accumulating; the
// weight memory read, the multiplier and the accumulator form a three-stage
// pipe. Once the last coordinate of a vector is taken, input stalls while
// the pipe drains and the result is registered, and longer if the previous
// result is still waiting at the output. A training vector whose class
// differs from its label then runs an update pass over the weight memory,
// one entry per clock, over the coordinates in the vector.
// After reset the weight memory is zeroed by a clearing pass over all
// MAX_DIMENSION entries during which no coordinate is taken; dimension writes
// are taken at any time.
`default_nettype none

module perceptron_train_classify
  import ptc_pkg::*;
#(
  parameter int MAX_DIMENSION = 512
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [DimW-1:0]          cfg_dimension,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_kind,
  input  wire logic signed [CoordW-1:0] in_coordinate,
  input  wire logic                     in_label,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_predicted_class,
  output logic                          out_weights_updated,
  output logic                          out_was_training
);

  localparam int AW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DW = ($clog2(MAX_DIMENSION + 1) > DimW) ? $clog2(MAX_DIMENSION + 1) : DimW;

  state_t state_r, state_nxt;

  logic [DimW-1:0] dim_r;
  logic [DW-1:0]   dim_eff;
  logic [AW-1:0]   idx_r;
  logic [AW-1:0]   last_idx_r;
  logic [AW-1:0]   upd_addr_r;
  logic [AW-1:0]   wr_addr_r;
  logic            rd_on_r;
  logic            wr_pend_r;
  logic            s1_v_r, s1_last_r;
  logic            s2_v_r, s2_last_r;
  logic signed [CoordW-1:0] s1_x_r;
  logic            fin_train_r;
  logic            fin_label_r;
  logic            out_valid_r;
  logic            out_class_r;
  logic            out_upd_r;
  logic            out_train_r;

  logic            in_acc;
  logic            is_last;
  logic            out_free;
  logic            fin_go;
  logic            acc_pos;
  logic            mismatch;

  logic signed [CoordW-1:0] vbuf_mem [MAX_DIMENSION];
  logic signed [CoordW-1:0] vbuf_rd_r;
  logic signed [CoordW-1:0] w_rd;

  mac_ctl_t        mac_ctl;
  wmem_ctl_t       wmem_ctl;
  logic [AW-1:0]   w_rd_addr;
  logic [AW-1:0]   w_wr_addr;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DimW'(1);
    end else if (cfg_valid && cfg_ready) begin
      dim_r <= cfg_dimension;
    end
  end

  always_comb begin
    priority if (dim_r == '0) begin
      dim_eff = DW'(1);
    end else if (DW'(dim_r) > DW'(MAX_DIMENSION)) begin
      dim_eff = DW'(MAX_DIMENSION);
    end else begin
      dim_eff = DW'(dim_r);
    end
  end

  // input side
  assign in_stall = (state_r != ST_RUN) || (s1_v_r && s1_last_r) || (s2_v_r && s2_last_r);
  assign in_acc   = in_valid && !in_stall;
  assign is_last  = (DW'(idx_r) + DW'(1)) >= dim_eff;

  assign out_free = !out_valid_r || !out_stall;
  assign fin_go   = (state_r == ST_FIN) && out_free;
  assign mismatch = (fin_train_r == KIND_TRAIN) && (acc_pos != fin_label_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: if (upd_addr_r == AW'(MAX_DIMENSION - 1)) state_nxt = ST_RUN;
      ST_RUN: if (s2_v_r && s2_last_r) state_nxt = ST_FIN;
      ST_FIN: if (out_free) state_nxt = mismatch ? ST_UPD : ST_RUN;
      ST_UPD: if (!rd_on_r && !wr_pend_r) state_nxt = ST_RUN;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      upd_addr_r  <= '0;
      rd_on_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= in_acc;
      s2_v_r  <= s1_v_r;
      if (in_acc) begin
        idx_r <= is_last ? '0 : idx_r + AW'(1);
      end
      out_valid_r <= fin_go || (out_valid_r && out_stall);
      wr_pend_r <= (state_r == ST_UPD) && rd_on_r;
      priority if (state_r == ST_CLR) begin
        upd_addr_r <= upd_addr_r + AW'(1);
      end else if (fin_go) begin
        upd_addr_r <= '0;
        rd_on_r    <= mismatch;
      end else if (state_r == ST_UPD && rd_on_r) begin
        if (upd_addr_r == last_idx_r) begin
          rd_on_r <= 1'b0;
        end else begin
          upd_addr_r <= upd_addr_r + AW'(1);
        end
      end else begin
        upd_addr_r <= upd_addr_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r    <= in_coordinate;
      s1_last_r <= is_last;
      if (is_last) begin
        last_idx_r  <= idx_r;
        fin_train_r <= in_kind;
        fin_label_r <= in_label;
      end
    end
    s2_last_r <= s1_last_r;
    wr_addr_r <= upd_addr_r;
    if (fin_go) begin
      out_class_r <= acc_pos;
      out_upd_r   <= mismatch;
      out_train_r <= (fin_train_r == KIND_TRAIN);
    end
  end

  // vector buffer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      vbuf_mem[idx_r] <= in_coordinate;
    end
    vbuf_rd_r <= vbuf_mem[upd_addr_r];
  end

  // weight memory
  assign w_rd_addr      = (state_r == ST_UPD) ? upd_addr_r : idx_r;
  assign w_wr_addr      = (state_r == ST_CLR) ? upd_addr_r : wr_addr_r;
  assign wmem_ctl.wr_en = (state_r == ST_CLR) || wr_pend_r;
  assign wmem_ctl.clear = (state_r == ST_CLR);
  assign wmem_ctl.add   = fin_label_r;

  ptc_wmem #(
    .Depth (MAX_DIMENSION),
    .AddrW (AW)
  ) u_wmem (
    .clk      (clk),
    .ctl      (wmem_ctl),
    .rd_addr  (w_rd_addr),
    .wr_addr  (w_wr_addr),
    .vec_data (vbuf_rd_r),
    .rd_data  (w_rd)
  );

  assign mac_ctl.mul_en  = s1_v_r;
  assign mac_ctl.acc_en  = s2_v_r;
  assign mac_ctl.acc_clr = fin_go;

  ptc_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .x       (s1_x_r),
    .w       (w_rd),
    .acc_pos (acc_pos)
  );

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_class_r;
  assign out_weights_updated = out_upd_r;
  assign out_was_training    = out_train_r;

endmodule

`default_nettype wire

// ===== hdl/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks on the perceptron block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_predicted_class,
  input wire logic out_weights_updated,
  input wire logic out_was_training
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_predicted_class)
      && $stable(out_weights_updated) && $stable(out_was_training))
    else $error("stalled result changed");

  // only a training vector can update weights
  a_upd_train: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_weights_updated || out_was_training)
    else $error("update reported on classify vector");

  // clearing pass follows reset, no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not held after reset");

endmodule

bind perceptron_train_classify ptc_checker u_ptc_checker (.*);

`default_nettype wire
